### rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/mcdc_pkg.sv
// Types, constants and helper functions of the pointer gesture classifier.
package mcdc_pkg;

  localparam int COORD_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int WHEEL_BITS = 16;
  localparam int BTN_BITS   = 8;
  localparam int GBTN_BITS  = 3;
  localparam int KIND_BITS  = 3;
  localparam int TYPE_BITS  = 2;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 1;
  localparam int SQ_BITS    = 16;
  localparam int DT_BITS    = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam int ABS_CMP_BITS = (COORD_BITS > 17) ? COORD_BITS : 17;
  localparam int ABS_LIMIT  = 65535;

  localparam logic [CFG_BITS-1:0] MAX_MOVE_SQ_RST  = CFG_BITS'(5);
  localparam logic [CFG_BITS-1:0] MAX_CLICK_MS_RST = CFG_BITS'(250);
  localparam logic [GBTN_BITS-1:0] BTN_MASK = GBTN_BITS'(7);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int LVL_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [TYPE_BITS-1:0] {
    RQ_POINTER = 2'd0,
    RQ_WHEEL   = 2'd1,
    RQ_POLL    = 2'd2
  } req_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_MOVE_SQ  = 1'd0,
    CFG_MAX_CLICK_MS = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  typedef enum logic [KIND_BITS-1:0] {
    EV_MOVE  = 3'd0,
    EV_CLICK = 3'd1,
    EV_DBL   = 3'd2,
    EV_DRAG  = 3'd3,
    EV_WHEEL = 3'd4
  } kind_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]         req_type;
    logic [BTN_BITS-1:0]          buttons;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [WHEEL_BITS-1:0] wheel_delta;
    logic [TIME_BITS-1:0]         now_ms;
  } req_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]         event_kind;
    logic [BTN_BITS-1:0]          event_buttons;
    logic signed [COORD_BITS-1:0] event_x;
    logic signed [COORD_BITS-1:0] event_y;
    logic signed [WHEEL_BITS-1:0] event_wheel;
    logic                         last_of_run;
  } evt_t;

  // Up to two events produced by one request, in order.
  typedef struct packed {
    logic [1:0] count;
    evt_t       ev0;
    evt_t       ev1;
  } push_t;

  typedef struct packed {
    logic                space;
    logic [LVL_BITS-1:0] level;
  } fifo_stat_t;

  function automatic evt_t make_evt(kind_t kind, logic [BTN_BITS-1:0] btn,
                                    logic signed [COORD_BITS-1:0] x,
                                    logic signed [COORD_BITS-1:0] y,
                                    logic signed [WHEEL_BITS-1:0] wheel,
                                    logic last);
    evt_t e;
    e.event_kind    = kind;
    e.event_buttons = btn;
    e.event_x       = x;
    e.event_y       = y;
    e.event_wheel   = wheel;
    e.last_of_run   = last;
    return e;
  endfunction

  function automatic logic one_bit(logic [GBTN_BITS-1:0] v);
    return (v != '0) && ((v & (v - GBTN_BITS'(1))) == '0);
  endfunction

endpackage

### rtl/mcdc_classify.sv
// Gesture state machine and event decision for one request per cycle while fire is high.
module mcdc_classify import mcdc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  req_t                item,
  input  logic                fire,
  input  logic [CFG_BITS-1:0] max_move_sq,
  input  logic [CFG_BITS-1:0] max_click_ms,
  output push_t               push
);

  phase_t                       phase, phase_next;
  logic [GBTN_BITS-1:0]         gesture_button, gesture_button_next;
  logic [BTN_BITS-1:0]          press_buttons, press_buttons_next;
  logic signed [COORD_BITS-1:0] press_x, press_x_next;
  logic signed [COORD_BITS-1:0] press_y, press_y_next;
  logic [TIME_BITS-1:0]         press_time, press_time_next;
  logic [BTN_BITS-1:0]          prev_buttons;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic                         upd_prev;

  logic [BTN_BITS-1:0]          cur_btn;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        ax, ay;
  logic [SQ_BITS-1:0]           sx, sy;
  logic [2*SQ_BITS-1:0]         sqx, sqy;
  logic [2*SQ_BITS:0]           dist_sq;
  logic [TIME_BITS-1:0]         dt;
  logic                         big, far_d, late, fol;
  logic [GBTN_BITS-1:0]         changes, pressed, released;
  phase_t                       ph;

  logic  a_en, b_en, cancel, start;
  kind_t a_kind, b_kind;
  evt_t  ev_a, ev_b;

  // Current point: idle polls reuse the last reported point.
  always_comb begin
    if (item.req_type == RQ_POLL) begin
      cur_btn = prev_buttons;
      cur_x   = prev_x;
      cur_y   = prev_y;
    end else begin
      cur_btn = item.buttons;
      cur_x   = item.pos_x;
      cur_y   = item.pos_y;
    end
  end

  // Distance and elapsed time against the press.
  always_comb begin
    dx      = {cur_x[COORD_BITS-1], cur_x} - {press_x[COORD_BITS-1], press_x};
    dy      = {cur_y[COORD_BITS-1], cur_y} - {press_y[COORD_BITS-1], press_y};
    ax      = COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
    ay      = COORD_BITS'(dy[COORD_BITS] ? -dy : dy);
    big     = (ABS_CMP_BITS'(ax) > ABS_CMP_BITS'(ABS_LIMIT)) ||
              (ABS_CMP_BITS'(ay) > ABS_CMP_BITS'(ABS_LIMIT));
    sx      = SQ_BITS'(ax);
    sy      = SQ_BITS'(ay);
    sqx     = sx * sx;
    sqy     = sy * sy;
    dist_sq = {1'b0, sqx} + {1'b0, sqy};
    far_d   = dist_sq > (2*SQ_BITS+1)'(max_move_sq);
    dt      = item.now_ms - press_time;
    late    = DT_BITS'(dt) > DT_BITS'(max_click_ms);
    fol     = big || far_d || late;
  end

  always_comb begin
    unique case (phase)
      PH_PRESSED:  ph = PH_PRESSED;
      PH_RELEASED: ph = PH_RELEASED;
      default:     ph = PH_IDLE;
    endcase
    changes  = (prev_buttons[GBTN_BITS-1:0] ^ item.buttons[GBTN_BITS-1:0]) & BTN_MASK;
    pressed  = ~prev_buttons[GBTN_BITS-1:0] & item.buttons[GBTN_BITS-1:0] & BTN_MASK;
    released = prev_buttons[GBTN_BITS-1:0] & ~item.buttons[GBTN_BITS-1:0] & BTN_MASK;
  end

  // Every request yields an optional event at the press point (A), then an
  // optional event at the current point (B).
  always_comb begin
    a_en       = 1'b0;
    a_kind     = EV_MOVE;
    b_en       = 1'b0;
    b_kind     = EV_MOVE;
    cancel     = 1'b0;
    start      = 1'b0;
    upd_prev   = 1'b0;
    phase_next = ph;
    press_time_next = press_time;

    unique case (item.req_type)
      RQ_POINTER: begin
        upd_prev = 1'b1;
        if (changes != '0) begin
          if (released == '0 && one_bit(pressed)) begin
            unique case (ph)
              PH_IDLE: start = 1'b1;
              PH_RELEASED: begin
                if (gesture_button != pressed) begin
                  a_en   = 1'b1;
                  a_kind = EV_CLICK;
                  start  = 1'b1;
                end else begin
                  a_en = 1'b1;
                  if (fol) begin
                    a_kind = EV_CLICK;
                    b_en   = 1'b1;
                    b_kind = EV_DRAG;
                    cancel = 1'b1;
                  end else begin
                    a_kind = EV_DBL;
                  end
                  phase_next = PH_IDLE;
                end
              end
              default: begin
                a_en   = 1'b1;
                a_kind = EV_MOVE;
                start  = 1'b1;
              end
            endcase
          end else if (pressed == '0 && one_bit(released)) begin
            unique case (ph)
              PH_IDLE: b_en = 1'b1;
              PH_PRESSED: begin
                if (fol || gesture_button != released) begin
                  a_en       = 1'b1;
                  a_kind     = fol ? EV_DRAG : EV_CLICK;
                  b_en       = 1'b1;
                  cancel     = 1'b1;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next      = PH_RELEASED;
                  press_time_next = item.now_ms;
                end
              end
              default: begin
                a_en       = 1'b1;
                a_kind     = EV_CLICK;
                b_en       = 1'b1;
                cancel     = 1'b1;
                phase_next = PH_IDLE;
              end
            endcase
          end else begin
            // several buttons at once: cancel the gesture
            b_en = 1'b1;
            if (ph != PH_IDLE) begin
              a_en   = 1'b1;
              a_kind = (ph == PH_PRESSED) ? EV_DRAG : EV_CLICK;
              cancel = 1'b1;
            end
            phase_next = PH_IDLE;
          end
        end else begin
          if (ph == PH_IDLE) begin
            b_en = 1'b1;
          end else if (fol) begin
            a_en       = 1'b1;
            a_kind     = (ph == PH_PRESSED) ? EV_DRAG : EV_CLICK;
            b_en       = 1'b1;
            cancel     = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      RQ_WHEEL: begin
        upd_prev   = 1'b1;
        a_en       = (ph != PH_IDLE);
        a_kind     = (ph == PH_PRESSED) ? EV_MOVE : EV_CLICK;
        b_en       = 1'b1;
        b_kind     = EV_WHEEL;
        phase_next = PH_IDLE;
      end
      RQ_POLL: begin
        if (ph != PH_IDLE && late) begin
          a_en       = 1'b1;
          a_kind     = (ph == PH_PRESSED) ? EV_DRAG : EV_CLICK;
          b_en       = 1'b1;
          cancel     = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase

    // drop the trailing move of a cancel pair when the pointer never left
    if (cancel && b_kind == EV_MOVE && cur_x == press_x && cur_y == press_y) begin
      b_en = 1'b0;
    end

    gesture_button_next = gesture_button;
    press_buttons_next  = press_buttons;
    press_x_next        = press_x;
    press_y_next        = press_y;
    if (start) begin
      gesture_button_next = pressed;
      press_buttons_next  = item.buttons;
      press_x_next        = item.pos_x;
      press_y_next        = item.pos_y;
      press_time_next     = item.now_ms;
      phase_next          = PH_PRESSED;
    end
  end

  always_comb begin
    ev_a = make_evt(a_kind, press_buttons, press_x, press_y, '0, !b_en);
    ev_b = make_evt(b_kind, cur_btn, cur_x, cur_y,
                    (b_kind == EV_WHEEL) ? item.wheel_delta : '0, 1'b1);
    push.count = {1'b0, a_en} + {1'b0, b_en};
    push.ev0   = a_en ? ev_a : ev_b;
    push.ev1   = ev_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      gesture_button <= '0;
      press_buttons  <= '0;
      press_x        <= '0;
      press_y        <= '0;
      press_time     <= '0;
      prev_buttons   <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      gesture_button <= gesture_button_next;
      press_buttons  <= press_buttons_next;
      press_x        <= press_x_next;
      press_y        <= press_y_next;
      press_time     <= press_time_next;
      if (upd_prev) begin
        prev_buttons <= item.buttons;
        prev_x       <= item.pos_x;
        prev_y       <= item.pos_y;
      end
    end
  end

endmodule

### rtl/mcdc_evt_fifo.sv
// Small event queue: takes up to two events per cycle, hands out one while evt_ready is high.
module mcdc_evt_fifo import mcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_en,
  input  push_t      push,
  output logic       evt_valid,
  input  logic       evt_ready,
  output evt_t       evt,
  output fifo_stat_t stat
);

  evt_t                mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [LVL_BITS-1:0] level;
  logic [1:0]          push_n;
  logic                pop;

  assign push_n     = push_en ? push.count : 2'd0;
  assign pop        = evt_valid && evt_ready;
  assign evt_valid  = (level != '0);
  assign evt        = mem[rd_ptr];
  assign stat.space = (level <= LVL_BITS'(FIFO_DEPTH - 2));
  assign stat.level = level;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push.ev0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PTR_BITS'(1)] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      level  <= level + LVL_BITS'(push_n) - LVL_BITS'(pop);
    end
  end

endmodule

### rtl/mouse_click_drag_classifier.sv
// Top level of the pointer gesture classifier: request register, settings, event queue.
//
// Usage:
//   req channel (req_valid/req_ready/req): one pointer report, wheel report or
//     idle poll per request, each with its millisecond timestamp.
//   evt channel (evt_valid/evt_ready/evt): move, click, double-click, drag
//     start and wheel events; last_of_run marks the final event of a request.
//     A request yields zero, one or two events.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//     max_move_sq or max_click_ms only while no request is in flight.
// Path: an accepted request waits in the request register until it fires, is then
//   classified, and its events pass through the queue before they are offered on evt.
// Throughput: one request per cycle while each yields at most one event and evt_ready
//   stays high; the events of a request leave the single output port one at a time.
//   The classifier fires only when the four-entry event queue has room for two.
// Reset (rst, synchronous): gesture machine to idle, stored points and times to
//   zero, max_move_sq to 5, max_click_ms to 250, queue empty.
// Receiver stall: events wait in the queue; once it is nearly full the held
//   request stays put and req_ready drops until space frees up.
`include "assert_macros.svh"

module mouse_click_drag_classifier import mcdc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  req_t                    req,
  output logic                    evt_valid,
  input  logic                    evt_ready,
  output evt_t                    evt,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  // Held request and its valid flag.
  req_t       req_q;
  logic       req_q_valid;
  logic       fire;

  logic [CFG_BITS-1:0] max_move_sq;
  logic [CFG_BITS-1:0] max_click_ms;

  push_t      push;
  fifo_stat_t fifo_stat;

  // Classify the held request as soon as the queue can take two events.
  assign fire      = req_q_valid && fifo_stat.space;
  assign req_ready = !req_q_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_q_valid <= 1'b1;
    end else if (fire) begin
      req_q_valid <= 1'b0;
    end
  end

  // Payload register: load on every accepted request, hold otherwise.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_move_sq  <= MAX_MOVE_SQ_RST;
      max_click_ms <= MAX_CLICK_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_MOVE_SQ:  max_move_sq  <= cfg_data;
        CFG_MAX_CLICK_MS: max_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mcdc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .item         (req_q),
    .fire         (fire),
    .max_move_sq  (max_move_sq),
    .max_click_ms (max_click_ms),
    .push         (push)
  );

  mcdc_evt_fifo u_evt_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (fire),
    .push      (push),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .stat      (fifo_stat)
  );

  // A held request that is not classified stays, unchanged.
  `ASSERT_ALWAYS(a_req_hold, clk, rst,
    (req_q_valid && !fire) |=> (req_q_valid && $stable(req_q)), "held request lost")
  // The queue never overfills.
  `ASSERT_NEVER(a_fifo_over, clk, rst,
    fifo_stat.level > LVL_BITS'(FIFO_DEPTH), "event queue overflow")
  // Without a push or a pop the queue level holds.
  `ASSERT_ALWAYS(a_fifo_level, clk, rst,
    (!fire && !(evt_valid && evt_ready)) |=> $stable(fifo_stat.level),
    "event queue level moved without traffic")

endmodule
